>>> hw/rtl/utf8_to_utf16_decoder_assert.svh
// Assertion helpers for the UTF-8 decoder.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define U8U16_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define U8U16_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CuW   = 16;
  localparam int unsigned PendW = 3;

  localparam logic [ByteW-1:0] AsciiMask = 8'h80;
  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] PayMask   = 8'h3f;
  localparam logic [ByteW-1:0] FullMask  = 8'hff;

  // Result of one decode step.
  typedef struct packed {
    logic           emit;
    logic [CuW-1:0] code_unit;
    logic           has_char;
    logic           decode_error;
    logic           string_end;
  } step_res_t;

  // Continuation bytes announced by a lead byte (leading ones minus one; zero for a byte with no leading one).
  function automatic logic [PendW-1:0] lead_pending(input logic [ByteW-1:0] b);
    logic [PendW-1:0] n;
    priority casez (b)
      8'b11111111: n = 3'd7;
      8'b11111110: n = 3'd6;
      8'b1111110?: n = 3'd5;
      8'b111110??: n = 3'd4;
      8'b11110???: n = 3'd3;
      8'b1110????: n = 3'd2;
      8'b110?????: n = 3'd1;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  // Payload bits of a lead byte: everything below the first zero after the ones.
  function automatic logic [ByteW-1:0] lead_payload(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] keep;
    priority casez (b)
      8'b1111111?: keep = 8'h00;
      8'b1111110?: keep = 8'h01;
      8'b111110??: keep = 8'h03;
      8'b11110???: keep = 8'h07;
      8'b1110????: keep = 8'h0f;
      8'b110?????: keep = 8'h1f;
      8'b10??????: keep = PayMask;
      default:     keep = FullMask;
    endcase
    return b & keep;
  endfunction

endpackage

>>> hw/rtl/u8u16_step.sv
// One decode step: current state plus one byte in, next state and result out.
module u8u16_step #(
  parameter int unsigned UNIT_WIDTH = 16
) (
  input  logic [u8u16_pkg::PendW-1:0] pend_i,
  input  logic [UNIT_WIDTH-1:0]       part_i,
  input  logic                        halt_i,
  input  logic [u8u16_pkg::ByteW-1:0] byte_i,
  input  logic                        last_i,
  output logic [u8u16_pkg::PendW-1:0] pend_o,
  output logic [UNIT_WIDTH-1:0]       part_o,
  output logic                        halt_o,
  output u8u16_pkg::step_res_t        res_o
);

  logic [u8u16_pkg::PendW-1:0] pend_dec;
  logic [UNIT_WIDTH-1:0]       part_shift;
  logic                        is_ascii;
  logic                        is_cont;
  logic                        has_char;
  logic                        err;
  logic [u8u16_pkg::CuW-1:0]   unit;
  logic [u8u16_pkg::PendW-1:0] pend_nx;
  logic [UNIT_WIDTH-1:0]       part_nx;
  logic                        halt_nx;

  assign is_ascii   = (byte_i & u8u16_pkg::AsciiMask) == '0;
  assign is_cont    = (byte_i & u8u16_pkg::ContMask) == u8u16_pkg::ContTag;
  assign pend_dec   = pend_i - u8u16_pkg::PendW'(1);
  assign part_shift = {part_i[UNIT_WIDTH-7:0], byte_i[5:0]};

  always_comb begin
    has_char = 1'b0;
    err      = 1'b0;
    unit     = '0;
    pend_nx  = pend_i;
    part_nx  = part_i;
    halt_nx  = halt_i;
    if (!halt_i) begin
      if (is_ascii) begin
        // ASCII passes through even mid-sequence; sequence state is kept
        has_char = 1'b1;
        unit     = {{(u8u16_pkg::CuW-u8u16_pkg::ByteW){1'b0}}, byte_i};
      end else if (pend_i == '0) begin
        pend_nx = u8u16_pkg::lead_pending(byte_i);
        part_nx = {{(UNIT_WIDTH-u8u16_pkg::ByteW){1'b0}}, u8u16_pkg::lead_payload(byte_i)};
      end else begin
        pend_nx = pend_dec;
        if (!is_cont) begin
          err     = 1'b1;
          halt_nx = 1'b1;
        end else if (pend_dec == '0) begin
          has_char = 1'b1;
          unit     = part_shift[u8u16_pkg::CuW-1:0];
          part_nx  = '0;
        end else begin
          part_nx = part_shift;
        end
      end
    end
    if (last_i) begin
      pend_nx = '0;
      part_nx = '0;
      halt_nx = 1'b0;
    end
  end

  assign pend_o = pend_nx;
  assign part_o = part_nx;
  assign halt_o = halt_nx;

  assign res_o.emit         = has_char | err | last_i;
  assign res_o.code_unit    = unit;
  assign res_o.has_char     = has_char;
  assign res_o.decode_error = err;
  assign res_o.string_end   = last_i;

endmodule

>>> hw/rtl/utf8_to_utf16_decoder.sv
// Streaming UTF-8 decoder producing 16-bit code units. One byte word enters per
// clock on the slave side while the master side does not stall, tlast marking the
// final byte of a string; a result word leaves on the master side when a character
// completes (tuser[0]), when a bad continuation byte is seen (tuser[1], after which
// the rest of the string is skipped), or on the last byte (tlast). Other bytes
// inside a sequence produce no word. Sustained rate is one byte per clock when
// the master side does not stall. The accepting edge loads the input register; the
// decode logic feeds the result register, which loads when the held byte steps
// (two register stages). Throughput is limited only by master-side backpressure:
// the byte register holds while a result waits and the result register is full.
// An unfinished sequence at the end of a string is dropped silently. UNIT_WIDTH
// sets how many bits of a long sequence are kept; code units are always the low
// 16 bits.
`include "utf8_to_utf16_decoder_assert.svh"

module utf8_to_utf16_decoder #(
  parameter int unsigned UNIT_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,   // [7:0] data_byte
  input  logic                      s_axis_tlast_i,   // last_byte
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [15:0]               m_axis_tdata_o,   // [15:0] code_unit
  output logic [1:0]                m_axis_tuser_o,   // [0] has_char, [1] decode_error
  output logic                      m_axis_tlast_o    // string_end
);

  // input byte register
  logic                        in_vld_q;
  logic [u8u16_pkg::ByteW-1:0] in_byte_q;
  logic                        in_last_q;

  // decode state
  logic [u8u16_pkg::PendW-1:0] pend_q, pend_d;
  logic [UNIT_WIDTH-1:0]       part_q, part_d;
  logic                        halt_q, halt_d;

  // result register
  logic                        out_vld_q;
  u8u16_pkg::step_res_t        out_q;
  u8u16_pkg::step_res_t        res;

  logic adv;
  logic s_acc;

  u8u16_step #(
    .UNIT_WIDTH (UNIT_WIDTH)
  ) u_step (
    .pend_i (pend_q),
    .part_i (part_q),
    .halt_i (halt_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .pend_o (pend_d),
    .part_o (part_d),
    .halt_o (halt_d),
    .res_o  (res)
  );

  // Held word steps when it yields nothing or the result slot is free / draining.
  assign adv   = in_vld_q & (~res.emit | ~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | adv;
  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pend_q    <= '0;
      part_q    <= '0;
      halt_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        pend_q <= pend_d;
        part_q <= part_d;
        halt_q <= halt_d;
      end
      if (adv && res.emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (adv && res.emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q.code_unit;
  assign m_axis_tuser_o  = {out_q.decode_error, out_q.has_char};
  assign m_axis_tlast_o  = out_q.string_end;

  // No character is produced while the string is halted by an error.
  `U8U16_ASSERT_IMP(a_halt_silent, adv && halt_q, !res.has_char && !res.decode_error, "char or error while halted")
  // A processed last byte leaves the decoder clean.
  `U8U16_ASSERT_NXT(a_last_clears, adv && in_last_q, pend_q == '0 && part_q == '0 && !halt_q, "state not cleared after last byte")
  // A waiting result is never dropped.
  `U8U16_ASSERT_NXT(a_out_hold, out_vld_q && !m_axis_tready_i, out_vld_q && $stable(out_q), "stalled result lost or changed")

endmodule
